/* rtl/parking_distance_qualifier_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the parking distance qualifier.
// Every check is clocked on clk and switched off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PARKING_DISTANCE_QUALIFIER_TOP_ASSERT_SVH
`define PARKING_DISTANCE_QUALIFIER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PDQ_CHECK_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PDQ_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/pdq_pkg.sv */
// ----------------------------------------------------------------------------
// pdq_pkg
// Widths, register map, reset values and shared types of the parking
// distance qualifier.
// ----------------------------------------------------------------------------
`default_nettype none

package pdq_pkg;

    localparam int EchoWidth   = 15;
    localparam int HalfWidth   = EchoWidth - 1;
    localparam int DistWidth   = 10;
    localparam int LidarWidth  = 16;
    localparam int TimeWidth   = 32;
    localparam int ScaleWidth  = 24;
    localparam int RatioWidth  = 16;
    localparam int RatioShift  = 16;
    localparam int RatioProdWidth = DistWidth + ScaleWidth;

    localparam int EchoScaleWidth = 12;
    localparam int EchoShift      = 16;
    localparam int EchoProdWidth  = HalfWidth + EchoScaleWidth;
    localparam logic [EchoScaleWidth-1:0] ECHO_SCALE = 12'd2248;

    localparam int CfgAddrWidth = 5;
    localparam int CfgDataWidth = 32;
    localparam int CfgIndexWidth = 3;

    localparam logic [CfgIndexWidth-1:0] REG_SIDE_LIMIT  = 3'd0;
    localparam logic [CfgIndexWidth-1:0] REG_FRONT_LIMIT = 3'd1;
    localparam logic [CfgIndexWidth-1:0] REG_EMPTY_DELAY = 3'd2;
    localparam logic [CfgIndexWidth-1:0] REG_FRONT_SCALE = 3'd3;
    localparam logic [CfgIndexWidth-1:0] REG_SIDE_SCALE  = 3'd4;

    localparam logic [DistWidth-1:0]  SIDE_LIMIT_RESET  = 10'd400;
    localparam logic [DistWidth-1:0]  FRONT_LIMIT_RESET = 10'd800;
    localparam logic [TimeWidth-1:0]  EMPTY_DELAY_RESET = 32'd30000;
    localparam logic [ScaleWidth-1:0] FRONT_SCALE_RESET = 24'd65536;
    localparam logic [ScaleWidth-1:0] SIDE_SCALE_RESET  = 24'd65536;

    typedef struct packed {
        logic [DistWidth-1:0]  side_limit;
        logic [DistWidth-1:0]  front_limit;
        logic [TimeWidth-1:0]  empty_delay;
        logic [ScaleWidth-1:0] front_scale;
        logic [ScaleWidth-1:0] side_scale;
    } pdq_cfg_t;

    typedef struct packed {
        logic [DistWidth-1:0] cm;
        logic                 out_of_range;
    } pdq_side_t;

endpackage

`default_nettype wire

/* rtl/pdq_cfg_regs.sv */
// ----------------------------------------------------------------------------
// pdq_cfg_regs
// Configuration register file behind a simple APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module pdq_cfg_regs (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [pdq_pkg::CfgAddrWidth-1:0]  paddr,
    input  wire logic [pdq_pkg::CfgDataWidth-1:0]  pwdata,
    output logic      [pdq_pkg::CfgDataWidth-1:0]  prdata,
    output logic                                   pready,
    output pdq_pkg::pdq_cfg_t                      cfg
);

    import pdq_pkg::*;

    pdq_cfg_t                 cfg_reg;
    pdq_cfg_t                 cfg_next;
    logic                     wr_en;
    logic [CfgIndexWidth-1:0] index;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign index  = paddr[CfgAddrWidth-1:2];
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (index)
                REG_SIDE_LIMIT:  cfg_next.side_limit  = pwdata[DistWidth-1:0];
                REG_FRONT_LIMIT: cfg_next.front_limit = pwdata[DistWidth-1:0];
                REG_EMPTY_DELAY: cfg_next.empty_delay = pwdata[TimeWidth-1:0];
                REG_FRONT_SCALE: cfg_next.front_scale = pwdata[ScaleWidth-1:0];
                REG_SIDE_SCALE:  cfg_next.side_scale  = pwdata[ScaleWidth-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            REG_SIDE_LIMIT:  prdata = CfgDataWidth'(cfg_reg.side_limit);
            REG_FRONT_LIMIT: prdata = CfgDataWidth'(cfg_reg.front_limit);
            REG_EMPTY_DELAY: prdata = CfgDataWidth'(cfg_reg.empty_delay);
            REG_FRONT_SCALE: prdata = CfgDataWidth'(cfg_reg.front_scale);
            REG_SIDE_SCALE:  prdata = CfgDataWidth'(cfg_reg.side_scale);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.side_limit  <= SIDE_LIMIT_RESET;
            cfg_reg.front_limit <= FRONT_LIMIT_RESET;
            cfg_reg.empty_delay <= EMPTY_DELAY_RESET;
            cfg_reg.front_scale <= FRONT_SCALE_RESET;
            cfg_reg.side_scale  <= SIDE_SCALE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/pdq_echo_lane.sv */
// ----------------------------------------------------------------------------
// pdq_echo_lane
// Turns one ultrasonic echo width into a clamped distance in centimetres.
// ----------------------------------------------------------------------------
`default_nettype none

module pdq_echo_lane (
    input  wire logic [pdq_pkg::EchoWidth-1:0] echo_us,
    input  wire logic [pdq_pkg::DistWidth-1:0] side_limit,
    output pdq_pkg::pdq_side_t                 side
);

    import pdq_pkg::*;

    logic [HalfWidth-1:0]     half;
    logic [EchoProdWidth-1:0] prod;
    logic [DistWidth-1:0]     raw_cm;
    logic [DistWidth-1:0]     cm;

    assign half   = echo_us[EchoWidth-1:1];
    assign prod   = EchoProdWidth'(half) * EchoProdWidth'(ECHO_SCALE);
    assign raw_cm = prod[EchoShift +: DistWidth];

    // A timeout or an overlong echo reads as the limit itself.
    assign cm = ((raw_cm == '0) || (raw_cm > side_limit)) ? side_limit : raw_cm;

    assign side.cm           = cm;
    assign side.out_of_range = (cm >= side_limit);

endmodule

`default_nettype wire

/* rtl/pdq_merge.sv */
// ----------------------------------------------------------------------------
// pdq_merge
// Combines the left and right lanes into one side distance and flags a
// near reading on the right.
// ----------------------------------------------------------------------------
`default_nettype none

module pdq_merge (
    input  wire pdq_pkg::pdq_side_t             left,
    input  wire pdq_pkg::pdq_side_t             right,
    input  wire logic [pdq_pkg::DistWidth-1:0]  side_limit,
    output logic      [pdq_pkg::DistWidth-1:0]  side_cm,
    output logic                                near
);

    import pdq_pkg::*;

    logic [DistWidth:0] sum;

    assign sum = {1'b0, left.cm} + {1'b0, right.cm};

    always_comb
    begin
        if (left.out_of_range && right.out_of_range)
        begin
            side_cm = side_limit;
        end
        else if (left.out_of_range)
        begin
            side_cm = right.cm;
        end
        else if (right.out_of_range)
        begin
            side_cm = left.cm;
        end
        else
        begin
            side_cm = sum[DistWidth:1];
        end
    end

    assign near = (right.cm < (side_limit >> 1));

endmodule

`default_nettype wire

/* rtl/pdq_ratio_lane.sv */
// ----------------------------------------------------------------------------
// pdq_ratio_lane
// Forms a saturated Q8.8 ratio from a distance and a reciprocal scale.
// ----------------------------------------------------------------------------
`default_nettype none

module pdq_ratio_lane (
    input  wire logic [pdq_pkg::DistWidth-1:0]  dist_cm,
    input  wire logic [pdq_pkg::ScaleWidth-1:0] scale,
    output logic      [pdq_pkg::RatioWidth-1:0] ratio
);

    import pdq_pkg::*;

    localparam int HighWidth = RatioProdWidth - RatioShift - RatioWidth;

    logic [RatioProdWidth-1:0] prod;

    assign prod = RatioProdWidth'(dist_cm) * RatioProdWidth'(scale);

    assign ratio = (prod[RatioProdWidth-1 -: HighWidth] != '0)
                 ? {RatioWidth{1'b1}}
                 : prod[RatioShift +: RatioWidth];

endmodule

`default_nettype wire

/* rtl/parking_distance_qualifier_top.sv */
// ----------------------------------------------------------------------------
// parking_distance_qualifier_top
// Qualifies ultrasonic side distances, a held lidar front distance, Q8.8
// ratios and a delayed garage-empty flag for every measurement beat.
// ----------------------------------------------------------------------------
// Usage:
// A measurement beat enters on in_valid when in_stall is low; each beat gives
// exactly one result beat on out_valid, taken when out_stall is low.
// The echo lanes, the side merge, the lidar hold and the empty timer sit in
// the first stage; the two ratio multipliers sit in front of the output
// register, so a result passes the first-stage registers and then the
// output register before it is offered on out_valid.
// A new beat may be taken in every cycle, giving one result per cycle.
// When out_stall is held, the output register and the first stage each keep
// one beat, after which in_stall rises until the output is taken again.
// Reset restores the valid flags, configuration registers and held state and
// empties the pipeline. Registers are to be written over the APB port only
// while the block is idle, which it does not enforce; pready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module parking_distance_qualifier_top (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [pdq_pkg::CfgAddrWidth-1:0]  paddr,
    input  wire logic [pdq_pkg::CfgDataWidth-1:0]  pwdata,
    output logic      [pdq_pkg::CfgDataWidth-1:0]  prdata,
    output logic                                   pready,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [pdq_pkg::EchoWidth-1:0]     left_echo_us,
    input  wire logic [pdq_pkg::EchoWidth-1:0]     right_echo_us,
    input  wire logic                              lidar_valid,
    input  wire logic [pdq_pkg::LidarWidth-1:0]    lidar_cm,
    input  wire logic [pdq_pkg::TimeWidth-1:0]     now_ms,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic      [pdq_pkg::DistWidth-1:0]     left_cm,
    output logic      [pdq_pkg::DistWidth-1:0]     right_cm,
    output logic      [pdq_pkg::DistWidth-1:0]     side_cm,
    output logic      [pdq_pkg::DistWidth-1:0]     front_cm,
    output logic      [pdq_pkg::RatioWidth-1:0]    front_ratio,
    output logic      [pdq_pkg::RatioWidth-1:0]    side_ratio,
    output logic                                   garage_empty
);

    import pdq_pkg::*;

    pdq_cfg_t  cfg;
    pdq_side_t left_lane;
    pdq_side_t right_lane;

    logic [DistWidth-1:0]  merged_side;
    logic                  near;
    logic                  lidar_ok;
    logic [TimeWidth-1:0]  elapsed;

    logic                  s2_en;
    logic                  s1_en;
    logic                  in_accept;

    logic                  s1_valid_reg;
    logic                  out_valid_reg;

    logic [DistWidth-1:0]  held_front_reg;
    logic [DistWidth-1:0]  held_front_next;
    logic                  confirmed_reg;
    logic                  confirmed_next;
    logic                  running_reg;
    logic                  running_next;
    logic [TimeWidth-1:0]  start_reg;
    logic [TimeWidth-1:0]  start_next;

    logic [DistWidth-1:0]  s1_left_reg;
    logic [DistWidth-1:0]  s1_right_reg;
    logic [DistWidth-1:0]  s1_side_reg;
    logic [DistWidth-1:0]  s1_front_reg;
    logic                  s1_empty_reg;

    logic [RatioWidth-1:0] front_ratio_next;
    logic [RatioWidth-1:0] side_ratio_next;

    logic [DistWidth-1:0]  left_cm_reg;
    logic [DistWidth-1:0]  right_cm_reg;
    logic [DistWidth-1:0]  side_cm_reg;
    logic [DistWidth-1:0]  front_cm_reg;
    logic [RatioWidth-1:0] front_ratio_reg;
    logic [RatioWidth-1:0] side_ratio_reg;
    logic                  garage_empty_reg;

    pdq_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pdq_echo_lane u_left_lane (
        .echo_us    (left_echo_us),
        .side_limit (cfg.side_limit),
        .side       (left_lane)
    );

    pdq_echo_lane u_right_lane (
        .echo_us    (right_echo_us),
        .side_limit (cfg.side_limit),
        .side       (right_lane)
    );

    pdq_merge u_merge (
        .left       (left_lane),
        .right      (right_lane),
        .side_limit (cfg.side_limit),
        .side_cm    (merged_side),
        .near       (near)
    );

    pdq_ratio_lane u_front_ratio (
        .dist_cm (s1_front_reg),
        .scale   (cfg.front_scale),
        .ratio   (front_ratio_next)
    );

    pdq_ratio_lane u_side_ratio (
        .dist_cm (s1_side_reg),
        .scale   (cfg.side_scale),
        .ratio   (side_ratio_next)
    );

    assign s2_en     = !out_valid_reg || !out_stall;
    assign s1_en     = !s1_valid_reg || s2_en;
    assign in_stall  = !s1_en;
    assign in_accept = in_valid && s1_en;

    assign lidar_ok = (lidar_cm != '0) && (lidar_cm <= LidarWidth'(cfg.front_limit));
    assign elapsed  = now_ms - start_reg;

    always_comb
    begin
        held_front_next = held_front_reg;
        if (lidar_valid)
        begin
            held_front_next = lidar_ok ? lidar_cm[DistWidth-1:0] : cfg.front_limit;
        end
    end

    // The start time is kept by a running flag, so a start at time zero works.
    always_comb
    begin
        confirmed_next = confirmed_reg;
        running_next   = running_reg;
        start_next     = start_reg;
        if (near)
        begin
            confirmed_next = 1'b0;
            running_next   = 1'b0;
        end
        else if (!running_reg)
        begin
            start_next   = now_ms;
            running_next = 1'b1;
        end
        else if (!confirmed_reg && (elapsed >= cfg.empty_delay))
        begin
            confirmed_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            held_front_reg <= FRONT_LIMIT_RESET;
            confirmed_reg  <= 1'b1;
            running_reg    <= 1'b0;
            start_reg      <= '0;
        end
        else
        begin
            if (s1_en)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_en)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (in_accept)
            begin
                held_front_reg <= held_front_next;
                confirmed_reg  <= confirmed_next;
                running_reg    <= running_next;
                start_reg      <= start_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_left_reg  <= left_lane.cm;
            s1_right_reg <= right_lane.cm;
            s1_side_reg  <= merged_side;
            s1_front_reg <= held_front_next;
            s1_empty_reg <= confirmed_next;
        end
        if (s2_en && s1_valid_reg)
        begin
            left_cm_reg      <= s1_left_reg;
            right_cm_reg     <= s1_right_reg;
            side_cm_reg      <= s1_side_reg;
            front_cm_reg     <= s1_front_reg;
            front_ratio_reg  <= front_ratio_next;
            side_ratio_reg   <= side_ratio_next;
            garage_empty_reg <= s1_empty_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign left_cm      = left_cm_reg;
    assign right_cm     = right_cm_reg;
    assign side_cm      = side_cm_reg;
    assign front_cm     = front_cm_reg;
    assign front_ratio  = front_ratio_reg;
    assign side_ratio   = side_ratio_reg;
    assign garage_empty = garage_empty_reg;

endmodule

`default_nettype wire

/* rtl/pdq_checker.sv */
// ----------------------------------------------------------------------------
// pdq_checker
// Port-level checks of the parking distance qualifier, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "parking_distance_qualifier_top_assert.svh"

module pdq_checker (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_stall,
    input  wire logic                             out_valid,
    input  wire logic                             out_stall,
    input  wire logic [pdq_pkg::DistWidth-1:0]    left_cm,
    input  wire logic [pdq_pkg::DistWidth-1:0]    right_cm,
    input  wire logic [pdq_pkg::DistWidth-1:0]    side_cm,
    input  wire logic [pdq_pkg::DistWidth-1:0]    front_cm,
    input  wire logic [pdq_pkg::RatioWidth-1:0]   front_ratio,
    input  wire logic [pdq_pkg::RatioWidth-1:0]   side_ratio,
    input  wire logic                             garage_empty
);

    import pdq_pkg::*;

    logic [DistWidth:0]   side_sum;
    logic [DistWidth-1:0] side_avg;

    assign side_sum = {1'b0, left_cm} + {1'b0, right_cm};
    assign side_avg = side_sum[DistWidth:1];

    // The input side only holds off while a finished beat is blocked.
    `PDQ_CHECK_NOW(a_stall_only_when_blocked, in_stall, out_valid && out_stall, "in_stall without a blocked output")

    // The combined side is always one side or the mean of both.
    `PDQ_CHECK_NOW(a_side_from_lanes, out_valid, (side_cm == left_cm) || (side_cm == right_cm) || (side_cm == side_avg), "side_cm not formed from the two sides")

    `PDQ_CHECK_NEXT(a_out_valid_holds, out_valid && out_stall, out_valid, "out_valid dropped while stalled")

    `PDQ_CHECK_NEXT(a_out_beat_holds, out_valid && out_stall, $stable(left_cm) && $stable(right_cm) && $stable(side_cm) && $stable(front_cm) && $stable(front_ratio) && $stable(side_ratio) && $stable(garage_empty), "output beat changed while stalled")

endmodule

bind parking_distance_qualifier_top pdq_checker u_pdq_checker (.*);

`default_nettype wire

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top - parking distance qualifier testbench
// Drives measurement beats into the qualifier and checks every result beat
// against a cycle-free model of the echo conversion, side merge, lidar hold,
// ratio scaling and garage-empty timer. Directed tests cover the extremes
// and the corner cases, a test holds out_stall for back-pressure, and random
// phases use several register settings, most idling randomly on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    import pdq_pkg::*;

    typedef struct packed {
        logic [EchoWidth-1:0]  left_echo_us;
        logic [EchoWidth-1:0]  right_echo_us;
        logic                  lidar_valid;
        logic [LidarWidth-1:0] lidar_cm;
        logic [TimeWidth-1:0]  now_ms;
    } measurement_t;

    typedef struct packed {
        logic [DistWidth-1:0]  left_cm;
        logic [DistWidth-1:0]  right_cm;
        logic [DistWidth-1:0]  side_cm;
        logic [DistWidth-1:0]  front_cm;
        logic [RatioWidth-1:0] front_ratio;
        logic [RatioWidth-1:0] side_ratio;
        logic                  garage_empty;
    } reading_t;

    logic                    clk;
    logic                    rst_n;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [CfgAddrWidth-1:0] paddr;
    logic [CfgDataWidth-1:0] pwdata;
    logic [CfgDataWidth-1:0] prdata;
    logic                    pready;
    logic                    in_valid;
    logic                    in_stall;
    logic [EchoWidth-1:0]    left_echo_us;
    logic [EchoWidth-1:0]    right_echo_us;
    logic                    lidar_valid;
    logic [LidarWidth-1:0]   lidar_cm;
    logic [TimeWidth-1:0]    now_ms;
    logic                    out_valid;
    logic                    out_stall;
    logic [DistWidth-1:0]    left_cm;
    logic [DistWidth-1:0]    right_cm;
    logic [DistWidth-1:0]    side_cm;
    logic [DistWidth-1:0]    front_cm;
    logic [RatioWidth-1:0]   front_ratio;
    logic [RatioWidth-1:0]   side_ratio;
    logic                    garage_empty;

    pdq_cfg_t             shadow_cfg;
    logic [DistWidth-1:0] front_hold_cm;
    logic                 empty_confirmed;
    logic                 timer_armed;
    logic [TimeWidth-1:0] timer_start_ms;

    reading_t       pending_readings[$];
    int             mismatch_count;
    int             send_idle_pct;
    int             recv_idle_pct;
    int             hold_request;
    int             hold_left;
    logic           car_near;
    logic [TimeWidth-1:0] clock_ms;

    parking_distance_qualifier_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .left_echo_us  (left_echo_us),
        .right_echo_us (right_echo_us),
        .lidar_valid   (lidar_valid),
        .lidar_cm      (lidar_cm),
        .now_ms        (now_ms),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .left_cm       (left_cm),
        .right_cm      (right_cm),
        .side_cm       (side_cm),
        .front_cm      (front_cm),
        .front_ratio   (front_ratio),
        .side_ratio    (side_ratio),
        .garage_empty  (garage_empty)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic logic [DistWidth-1:0] echo_to_dist(input logic [EchoWidth-1:0] echo);
        int unsigned cm_value;
        cm_value = ((int'(echo) >> 1) * int'(ECHO_SCALE)) >> EchoShift;
        if (cm_value == 0 || cm_value > shadow_cfg.side_limit)
            cm_value = 32'(shadow_cfg.side_limit);
        return cm_value[DistWidth-1:0];
    endfunction

    function automatic logic [RatioWidth-1:0] scale_q88(input logic [DistWidth-1:0] dist_cm,
                                                        input logic [ScaleWidth-1:0] scale);
        logic [RatioProdWidth-1:0] prod;
        prod = RatioProdWidth'(dist_cm) * RatioProdWidth'(scale);
        if (prod[RatioProdWidth-1:RatioShift] > {RatioWidth{1'b1}})
            return {RatioWidth{1'b1}};
        return prod[RatioShift+RatioWidth-1:RatioShift];
    endfunction

    function automatic reading_t qualify_measurement(input measurement_t m);
        reading_t             r;
        logic                 left_out;
        logic                 right_out;
        logic [TimeWidth-1:0] elapsed;
        r.left_cm  = echo_to_dist(m.left_echo_us);
        r.right_cm = echo_to_dist(m.right_echo_us);
        left_out   = r.left_cm >= shadow_cfg.side_limit;
        right_out  = r.right_cm >= shadow_cfg.side_limit;
        if (left_out && right_out)
            r.side_cm = shadow_cfg.side_limit;
        else if (left_out)
            r.side_cm = r.right_cm;
        else if (right_out)
            r.side_cm = r.left_cm;
        else
            r.side_cm = DistWidth'(({1'b0, r.left_cm} + {1'b0, r.right_cm}) >> 1);
        if (m.lidar_valid)
        begin
            if (m.lidar_cm != 0 && m.lidar_cm <= shadow_cfg.front_limit)
                front_hold_cm = m.lidar_cm[DistWidth-1:0];
            else
                front_hold_cm = shadow_cfg.front_limit;
        end
        elapsed = m.now_ms - timer_start_ms;
        if (r.right_cm < (shadow_cfg.side_limit >> 1))
        begin
            empty_confirmed = 1'b0;
            timer_armed     = 1'b0;
        end
        else if (!timer_armed)
        begin
            timer_start_ms = m.now_ms;
            timer_armed    = 1'b1;
        end
        else if (!empty_confirmed && elapsed >= shadow_cfg.empty_delay)
        begin
            empty_confirmed = 1'b1;
        end
        r.front_cm     = front_hold_cm;
        r.front_ratio  = scale_q88(front_hold_cm, shadow_cfg.front_scale);
        r.side_ratio   = scale_q88(r.side_cm, shadow_cfg.side_scale);
        r.garage_empty = empty_confirmed;
        return r;
    endfunction

    function automatic measurement_t random_measurement();
        measurement_t m;
        if ($urandom_range(9) == 0)
            car_near = !car_near;
        if (car_near)
            m.right_echo_us = EchoWidth'($urandom_range(0, 12000));
        else if ($urandom_range(4) < 3)
            m.right_echo_us = '0;
        else
            m.right_echo_us = EchoWidth'($urandom_range(20000, 30000));
        m.left_echo_us = ($urandom_range(4) == 0) ? 15'd0 : 15'($urandom_range(0, 30000));
        m.lidar_valid  = 1'($urandom_range(1));
        case ($urandom_range(3))
            0:       m.lidar_cm = $urandom_range(1) ? {LidarWidth{1'b1}} : '0;
            1:       m.lidar_cm = LidarWidth'($urandom_range(0, 1100));
            default: m.lidar_cm = LidarWidth'($urandom_range(0, 65535));
        endcase
        if ($urandom_range(19) == 0)
            clock_ms = $urandom();
        else
            clock_ms = clock_ms + $urandom_range(0, 400);
        m.now_ms = clock_ms;
        return m;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin : check_readings
        reading_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_readings.size() == 0)
            begin
                $error("result beat arrived with no reading pending");
                mismatch_count++;
            end
            else
            begin
                want = pending_readings.pop_front();
                check_field("left_cm", 32'(want.left_cm), 32'(left_cm));
                check_field("right_cm", 32'(want.right_cm), 32'(right_cm));
                check_field("side_cm", 32'(want.side_cm), 32'(side_cm));
                check_field("front_cm", 32'(want.front_cm), 32'(front_cm));
                check_field("front_ratio", 32'(want.front_ratio), 32'(front_ratio));
                check_field("side_ratio", 32'(want.side_ratio), 32'(side_ratio));
                check_field("garage_empty", 32'(want.garage_empty), 32'(garage_empty));
            end
        end
    end

    initial
    begin
        out_stall = 1'b0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0)
            begin
                out_stall = 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall = ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    task automatic send_beat(input measurement_t m);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid      = 1'b1;
        left_echo_us  = m.left_echo_us;
        right_echo_us = m.right_echo_us;
        lidar_valid   = m.lidar_valid;
        lidar_cm      = m.lidar_cm;
        now_ms        = m.now_ms;
        do
            @(posedge clk);
        while (in_stall);
        pending_readings.push_back(qualify_measurement(m));
    endtask

    task automatic send_meas(input int left_us, input int right_us, input logic lv,
                             input int lidar, input logic [TimeWidth-1:0] now);
        measurement_t m;
        m.left_echo_us  = EchoWidth'(left_us);
        m.right_echo_us = EchoWidth'(right_us);
        m.lidar_valid   = lv;
        m.lidar_cm      = LidarWidth'(lidar);
        m.now_ms        = now;
        send_beat(m);
    endtask

    task automatic wait_for_readings();
        @(negedge clk);
        in_valid = 1'b0;
        wait (pending_readings.size() == 0);
    endtask

    task automatic write_reg(input logic [CfgIndexWidth-1:0] index, input logic [31:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {index, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        case (index)
            REG_SIDE_LIMIT:  shadow_cfg.side_limit  = value[DistWidth-1:0];
            REG_FRONT_LIMIT: shadow_cfg.front_limit = value[DistWidth-1:0];
            REG_EMPTY_DELAY: shadow_cfg.empty_delay = value[TimeWidth-1:0];
            REG_FRONT_SCALE: shadow_cfg.front_scale = value[ScaleWidth-1:0];
            REG_SIDE_SCALE:  shadow_cfg.side_scale  = value[ScaleWidth-1:0];
            default: ;
        endcase
    endtask

    task automatic write_config(input pdq_cfg_t c);
        write_reg(REG_SIDE_LIMIT, 32'(c.side_limit));
        write_reg(REG_FRONT_LIMIT, 32'(c.front_limit));
        write_reg(REG_EMPTY_DELAY, 32'(c.empty_delay));
        write_reg(REG_FRONT_SCALE, 32'(c.front_scale));
        write_reg(REG_SIDE_SCALE, 32'(c.side_scale));
    endtask

    task automatic test_echo_conversion();
        send_meas(0, 0, 1'b1, 0, 32'd0);
        send_meas(58, 60, 1'b1, 1, 32'd10);
        send_meas(30000, 5000, 1'b0, 65535, 32'd20);
        send_meas(5000, 30000, 1'b1, 800, 32'd30);
        send_meas(10000, 20000, 1'b1, 801, 32'd40);
        send_meas(23324, 23324, 1'b1, 65535, 32'd50);
        send_meas(23300, 23360, 1'b0, 0, 32'd60);
        send_meas(23360, 23300, 1'b1, 400, 32'd70);
        send_meas(2, 30000, 1'b0, 12345, 32'hFFFF_FFFF);
        wait_for_readings();
    endtask

    task automatic test_empty_timer();
        write_reg(REG_EMPTY_DELAY, 32'd0);
        send_meas(5000, 5000, 1'b0, 0, 32'd100);
        send_meas(5000, 0, 1'b0, 0, 32'd100);
        send_meas(5000, 0, 1'b0, 0, 32'd100);
        wait_for_readings();
        write_reg(REG_EMPTY_DELAY, 32'd100);
        send_meas(5000, 5000, 1'b0, 0, 32'hFFFF_FFC0);
        send_meas(5000, 0, 1'b0, 0, 32'hFFFF_FFC0);
        send_meas(5000, 0, 1'b0, 0, 32'h0000_0010);
        send_meas(5000, 0, 1'b0, 0, 32'h0000_0024);
        wait_for_readings();
        write_reg(REG_EMPTY_DELAY, 32'hFFFF_FFFF);
        send_meas(5000, 5000, 1'b0, 0, 32'd3);
        send_meas(5000, 0, 1'b0, 0, 32'd5);
        send_meas(5000, 0, 1'b0, 0, 32'd6);
        send_meas(5000, 0, 1'b0, 0, 32'd4);
        wait_for_readings();
    endtask

    task automatic test_zero_limits();
        write_reg(REG_SIDE_LIMIT, 32'd0);
        write_reg(REG_FRONT_LIMIT, 32'd0);
        send_meas(0, 0, 1'b1, 5, 32'd200);
        send_meas(30000, 1000, 1'b1, 0, 32'd300);
        send_meas(12000, 60, 1'b0, 9, 32'd400);
        wait_for_readings();
    endtask

    task automatic test_unmapped_registers();
        write_config('{SIDE_LIMIT_RESET, FRONT_LIMIT_RESET, 32'd200,
                       FRONT_SCALE_RESET, SIDE_SCALE_RESET});
        for (int idx = int'(REG_SIDE_SCALE) + 1; idx < (1 << CfgIndexWidth); idx++)
            write_reg(CfgIndexWidth'(idx), $urandom());
        send_meas(8000, 20000, 1'b1, 700, 32'd1000);
        send_meas(20000, 8000, 1'b1, 900, 32'd1100);
        wait_for_readings();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 24;
        hold_request  = 60;
        repeat (30) send_beat(random_measurement());
        wait_for_readings();
        repeat (20) send_beat(random_measurement());
        wait_for_readings();
    endtask

    task automatic test_random_phases();
        pdq_cfg_t cfg;
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: cfg = '{10'd400, 10'd800, 32'd500, 24'd65536, 24'd65536};
                1: cfg = '{10'd1, 10'd1, 32'd0, 24'hFF_FFFF, 24'hFF_FFFF};
                2: cfg = '{10'd1023, 10'd1023, 32'hFFFF_FFFF, 24'd0, 24'd0};
                default:
                begin
                    cfg.side_limit  = DistWidth'($urandom_range(1, 1023));
                    cfg.front_limit = DistWidth'($urandom_range(1, 1023));
                    cfg.empty_delay = TimeWidth'($urandom_range(0, 1500));
                    cfg.front_scale = ScaleWidth'($urandom_range(0, 24'hFF_FFFF));
                    cfg.side_scale  = ScaleWidth'($urandom_range(0, 24'hFF_FFFF));
                end
            endcase
            // The fourth phase runs without any idling; the fifth crosses the time wrap.
            send_idle_pct = (phase == 3) ? 0 : 24;
            recv_idle_pct = (phase == 3) ? 0 : 24;
            if (phase == 4)
                clock_ms = 32'hFFFF_F000;
            write_config(cfg);
            repeat (100) send_beat(random_measurement());
            wait_for_readings();
        end
    endtask

    initial
    begin
        #3000000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        in_valid        = 1'b0;
        left_echo_us    = '0;
        right_echo_us   = '0;
        lidar_valid     = 1'b0;
        lidar_cm        = '0;
        now_ms          = '0;
        mismatch_count  = 0;
        send_idle_pct   = 24;
        recv_idle_pct   = 24;
        hold_request    = 0;
        car_near        = 1'b0;
        clock_ms        = '0;
        shadow_cfg      = '{SIDE_LIMIT_RESET, FRONT_LIMIT_RESET, EMPTY_DELAY_RESET,
                            FRONT_SCALE_RESET, SIDE_SCALE_RESET};
        front_hold_cm   = FRONT_LIMIT_RESET;
        empty_confirmed = 1'b1;
        timer_armed     = 1'b0;
        timer_start_ms  = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_echo_conversion();
        test_empty_timer();
        test_zero_limits();
        test_unmapped_registers();
        test_backpressure();
        test_random_phases();

        wait_for_readings();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

/* parking_distance_qualifier_top.f */
+incdir+rtl
rtl/pdq_pkg.sv
rtl/pdq_cfg_regs.sv
rtl/pdq_echo_lane.sv
rtl/pdq_merge.sv
rtl/pdq_ratio_lane.sv
rtl/parking_distance_qualifier_top.sv
rtl/pdq_checker.sv
tb/sv/tb_top.sv
